@@ src/jtm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtm_pkg: shared types and codes for the JTAG TAP master shifter
// Payload structs for both channels, operation codes and TAP belief codes.
// ----------------------------------------------------------------------------
package jtm_pkg;

  localparam int OP_W    = 3;
  localparam int INSTR_W = 10;
  localparam int DATA_W  = 16;
  localparam int ADDR_W  = 13;
  localparam int TAP_W   = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_RESET     = 3'd0;
  localparam logic [OP_W-1:0] OP_GO_IDLE   = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_IR   = 3'd2;
  localparam logic [OP_W-1:0] OP_SHIFT_DR  = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD_ADDR = 3'd4;

  // Believed TAP controller state
  localparam logic [TAP_W-1:0] TAP_RESET    = 3'd0;
  localparam logic [TAP_W-1:0] TAP_IDLE     = 3'd1;
  localparam logic [TAP_W-1:0] TAP_IR_SHIFT = 3'd2;
  localparam logic [TAP_W-1:0] TAP_IR_EXIT1 = 3'd3;
  localparam logic [TAP_W-1:0] TAP_DR_SHIFT = 3'd4;
  localparam logic [TAP_W-1:0] TAP_DR_EXIT1 = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [INSTR_W-1:0] instruction;
    logic [DATA_W-1:0]  data_word;
    logic [ADDR_W-1:0]  address;
    logic               exit_after;
    logic [DATA_W-1:0]  tdo_levels;
  } cmd_t;

  typedef struct packed {
    logic              pulse;
    logic              tms_level;
    logic              tdi_level;
    logic [DATA_W-1:0] captured_word;
    logic              last;
  } res_t;

  // Sequencer status toward the channel logic
  typedef struct packed {
    logic active;  // a result is offered this cycle
    logic last;    // offered result ends the operation
  } seq_stat_t;

endpackage

@@ src/jtag_tap_master_shifter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtag_tap_master_shifter: JTAG TAP master with TMS/TDI serializer
// Takes one operation per command transfer and returns one result transfer
// per TCK pulse, or a single non-pulse result when nothing is clocked.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   cmd     | in        | cmd_valid/cmd_ready  | cmd_t (op, fields, TDO)
//   res     | out       | res_valid/res_ready  | res_t (pulse, pins, last)
//
// After acceptance the sequencer produces the results of an operation in order,
// driven by the shared shift register and pulse counter, one bit per cycle
// while the res channel does not stall.
// cmd_ready is low from acceptance until the last result is registered.
// A stalled res channel holds the sequencer; rst clears the TAP belief to
// test logic reset and the held pins to zero.
// ----------------------------------------------------------------------------
module jtag_tap_master_shifter import jtm_pkg::*; #(
  parameter int IR_BITS      = 10,
  parameter int DATA_BITS    = 16,
  parameter int ADDRESS_BITS = 13
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  seq_stat_t stat;
  res_t      seq_res;
  logic      take;
  logic      step;

  assign cmd_ready = !stat.active;
  assign take      = cmd_valid && cmd_ready;
  assign step      = stat.active && (!res_valid || res_ready);

  jtm_seq #(
    .IR_BITS      (IR_BITS),
    .DATA_BITS    (DATA_BITS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .cmd  (cmd),
    .step (step),
    .stat (stat),
    .res  (seq_res)
  );

  // output register parts the sequencer from the result channel
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res <= seq_res;
  end

endmodule

@@ src/jtm_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtm_seq: TCK pulse sequencer
// Walks one operation through its TMS/TDI phases, one pulse per step (none for
// an operation with nothing to clock), using a shared shift register for all serial fields and one down counter.
// ----------------------------------------------------------------------------
module jtm_seq import jtm_pkg::*; #(
  parameter int IR_BITS      = 10,
  parameter int DATA_BITS    = 16,
  parameter int ADDRESS_BITS = 13
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  cmd_t      cmd,
  input  logic      step,
  output seq_stat_t stat,
  output res_t      res
);

  localparam int SHW_A   = (IR_BITS > DATA_BITS) ? IR_BITS : DATA_BITS;
  localparam int SHW     = (SHW_A > ADDRESS_BITS) ? SHW_A : ADDRESS_BITS;
  localparam int CNT_TOP = (SHW > 5) ? SHW : 5;
  localparam int CW      = $clog2(CNT_TOP);

  localparam logic [CW-1:0] RST_LAST = CW'(4);
  localparam logic [CW-1:0] IRH_LAST = CW'(3);
  localparam logic [CW-1:0] DRH_LAST = CW'(2);
  localparam logic [CW-1:0] IR_LAST  = CW'(IR_BITS - 1);
  localparam logic [CW-1:0] DR_LAST  = CW'(DATA_BITS - 1);
  localparam logic [CW-1:0] AD_LAST  = CW'(ADDRESS_BITS - 1);
  localparam logic [CW-1:0] CNT_ZERO = '0;

  localparam logic [DATA_W-1:0] CAP_MASK =
    (DATA_BITS >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((33'd1 << DATA_BITS) - 33'd1);

  localparam logic [3:0] S_WAIT    = 4'd0;
  localparam logic [3:0] S_RST     = 4'd1;
  localparam logic [3:0] S_GI_UPD  = 4'd2;
  localparam logic [3:0] S_GI_IDLE = 4'd3;
  localparam logic [3:0] S_IR_HDR  = 4'd4;
  localparam logic [3:0] S_IR_SH   = 4'd5;
  localparam logic [3:0] S_DR_HDR  = 4'd6;
  localparam logic [3:0] S_DATA    = 4'd7;
  localparam logic [3:0] S_ADDR    = 4'd8;
  localparam logic [3:0] S_NOP     = 4'd9;

  logic [3:0]        state;
  logic [TAP_W-1:0]  belief;
  logic              tms_pin;
  logic              tdi_pin;
  logic              ret_addr;   // address phase follows the go-idle
  logic              addr_mode;
  logic              esc;
  logic [CW-1:0]     cnt;
  logic [SHW-1:0]    sreg;
  logic [SHW-1:0]    addr_fit;
  logic [DATA_W-1:0] cap_word;

  logic [SHW+INSTR_W-1:0] instr_ext;
  logic [SHW+DATA_W-1:0]  data_ext;
  logic [SHW+ADDR_W-1:0]  addr_ext;
  logic                   in_exit1;
  logic                   cnt_end;
  res_t                   r;

  assign instr_ext = {{SHW{1'b0}}, cmd.instruction};
  assign data_ext  = {{SHW{1'b0}}, cmd.data_word};
  assign addr_ext  = {{SHW{1'b0}}, cmd.address};
  assign in_exit1  = (belief == TAP_IR_EXIT1) || (belief == TAP_DR_EXIT1);
  assign cnt_end   = (cnt == CNT_ZERO);

  always_comb begin
    r.pulse         = 1'b1;
    r.tms_level     = tms_pin;
    r.tdi_level     = tdi_pin;
    r.captured_word = '0;
    r.last          = 1'b0;
    case (state)
      S_RST: begin
        r.tms_level = 1'b1;
        r.last      = cnt_end;
      end
      S_GI_UPD: r.tms_level = 1'b1;
      S_GI_IDLE: begin
        r.tms_level = 1'b0;
        r.last      = !ret_addr;
      end
      S_IR_HDR: r.tms_level = (cnt >= DRH_LAST);
      S_IR_SH: begin
        r.tdi_level = sreg[0];
        if (cnt_end) r.tms_level = 1'b1;
      end
      S_DR_HDR: r.tms_level = (cnt == DRH_LAST);
      S_DATA: begin
        r.tdi_level = sreg[0];
        if (cnt_end && esc) r.tms_level = 1'b1;
        r.last = cnt_end && !esc;
      end
      S_ADDR: begin
        r.tdi_level = sreg[0];
        if (cnt_end) r.tms_level = 1'b1;
      end
      S_NOP: begin
        r.pulse = 1'b0;
        r.last  = 1'b1;
      end
      default: r.pulse = 1'b0;
    endcase
    if (r.last) r.captured_word = cap_word;
  end

  assign res         = r;
  assign stat.active = (state != S_WAIT);
  assign stat.last   = r.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_WAIT;
      belief   <= TAP_RESET;
      tms_pin  <= 1'b0;
      tdi_pin  <= 1'b0;
      ret_addr <= 1'b0;
    end else if (take) begin
      addr_mode <= (cmd.op == OP_LOAD_ADDR);
      esc       <= cmd.exit_after;
      addr_fit  <= addr_ext[SHW-1:0];
      cap_word  <= (cmd.op == OP_SHIFT_DR) ? (cmd.tdo_levels & CAP_MASK) : '0;
      ret_addr  <= 1'b0;
      case (cmd.op)
        OP_RESET: begin
          state <= S_RST;
          cnt   <= RST_LAST;
        end
        OP_GO_IDLE: state <= in_exit1 ? S_GI_UPD : S_GI_IDLE;
        OP_LOAD_IR: begin
          sreg <= instr_ext[SHW-1:0];
          cnt  <= IRH_LAST;
          state <= (belief == TAP_IDLE) ? S_IR_HDR : S_NOP;
        end
        OP_SHIFT_DR: begin
          sreg <= data_ext[SHW-1:0];
          if (belief == TAP_IDLE) begin
            state <= S_DR_HDR;
            cnt   <= DRH_LAST;
          end else begin
            state <= S_DATA;
            cnt   <= DR_LAST;
          end
        end
        OP_LOAD_ADDR: begin
          if (belief == TAP_IDLE) begin
            state    <= S_IR_HDR;
            cnt      <= IRH_LAST;
            sreg     <= instr_ext[SHW-1:0];
            ret_addr <= 1'b1;
          end else begin
            state  <= S_ADDR;
            cnt    <= AD_LAST;
            sreg   <= addr_ext[SHW-1:0];
            belief <= TAP_DR_SHIFT;
          end
        end
        default: state <= S_NOP;
      endcase
    end else if (step) begin
      tms_pin <= r.tms_level;
      tdi_pin <= r.tdi_level;
      cnt     <= cnt - CW'(1);
      case (state)
        S_RST: begin
          if (cnt_end) begin
            belief <= TAP_RESET;
            state  <= S_WAIT;
          end
        end
        S_GI_UPD: state <= S_GI_IDLE;
        S_GI_IDLE: begin
          belief <= TAP_IDLE;
          if (ret_addr) begin
            ret_addr <= 1'b0;
            state    <= S_DR_HDR;
            cnt      <= DRH_LAST;
          end else begin
            state <= S_WAIT;
          end
        end
        S_IR_HDR: begin
          if (cnt_end) begin
            belief <= TAP_IR_SHIFT;
            state  <= S_IR_SH;
            cnt    <= IR_LAST;
          end
        end
        S_IR_SH: begin
          sreg <= sreg >> 1;
          if (cnt_end) begin
            belief <= TAP_IR_EXIT1;
            state  <= S_GI_UPD;
          end
        end
        S_DR_HDR: begin
          if (cnt_end) begin
            belief <= TAP_DR_SHIFT;
            if (addr_mode) begin
              state <= S_ADDR;
              cnt   <= AD_LAST;
              sreg  <= addr_fit;
            end else begin
              state <= S_DATA;
              cnt   <= DR_LAST;
            end
          end
        end
        S_DATA: begin
          sreg <= sreg >> 1;
          if (cnt_end) begin
            if (esc) begin
              belief <= TAP_DR_EXIT1;
              state  <= S_GI_UPD;
            end else begin
              state <= S_WAIT;
            end
          end
        end
        S_ADDR: begin
          sreg <= sreg >> 1;
          if (cnt_end) begin
            belief <= TAP_DR_EXIT1;
            state  <= S_GI_UPD;
          end
        end
        S_NOP: state <= S_WAIT;
        default: state <= S_WAIT;
      endcase
    end
  end

endmodule

@@ src/jtm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtm_checker: port-level checks for the JTAG TAP master shifter
// Watches both channels and flags result sequencing slips.
// ----------------------------------------------------------------------------
module jtm_checker import jtm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input cmd_t cmd,
  input logic res_valid,
  input logic res_ready,
  input res_t res
);

  // a waiting command holds until its transfer
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("command changed while waiting");

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // every operation yields a result, so the block is busy right after a transfer
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("ready right after command transfer");

  // a non-pulse result stands alone
  a_nopulse_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.pulse |-> res.last)
    else $error("non-pulse result not marked last");

  // captured word only shows on the final result
  a_cap_on_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> res.captured_word == '0)
    else $error("captured word on a non-final result");

endmodule

bind jtag_tap_master_shifter jtm_checker u_jtm_checker (.*);

@@ test/jtag_tap_master_shifter_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtag_tap_master_shifter_check: pin-sequence checker for the TAP master
// Watches both channels. Each accepted command is expanded into the TCK
// pulses it should produce, tracking the believed TAP state and held pins.
// Each accepted result is compared field by field with the oldest pulse due.
// ----------------------------------------------------------------------------
module jtag_tap_master_shifter_check import jtm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  logic cmd_ready,
  input  cmd_t cmd,
  input  logic res_valid,
  input  logic res_ready,
  input  res_t res,
  output int   fail_count,
  output int   pending,
  output int   results_seen
);

  logic [TAP_W-1:0] belief;
  logic             tms_held;
  logic             tdi_held;
  res_t             pins_due[$];
  int               errors;
  int               seen;

  task automatic tick_pin(input logic pulse);
    res_t r;
    r.pulse         = pulse;
    r.tms_level     = tms_held;
    r.tdi_level     = tdi_held;
    r.captured_word = '0;
    r.last          = 1'b0;
    pins_due.push_back(r);
  endtask

  // From an exit1 state an update pulse comes first.
  task automatic settle_idle();
    if (belief == TAP_DR_EXIT1 || belief == TAP_IR_EXIT1) begin
      tms_held = 1'b1;
      tick_pin(1'b1);
    end
    tms_held = 1'b0;
    tick_pin(1'b1);
    belief = TAP_IDLE;
  endtask

  task automatic shift_ir(input logic [INSTR_W-1:0] ir);
    if (belief != TAP_IDLE) return;
    tms_held = 1'b1;
    tick_pin(1'b1);
    tick_pin(1'b1);
    tms_held = 1'b0;
    tick_pin(1'b1);
    tick_pin(1'b1);
    belief = TAP_IR_SHIFT;
    for (int i = 0; i < INSTR_W; i++) begin
      tdi_held = ir[i];
      if (i == INSTR_W - 1) begin
        tms_held = 1'b1;
        belief   = TAP_IR_EXIT1;
      end
      tick_pin(1'b1);
    end
    settle_idle();
  endtask

  task automatic enter_dr();
    if (belief == TAP_IDLE) begin
      tms_held = 1'b1;
      tick_pin(1'b1);
      tms_held = 1'b0;
      tick_pin(1'b1);
      tick_pin(1'b1);
      belief = TAP_DR_SHIFT;
    end
  endtask

  task automatic expand_cmd(input cmd_t c);
    int   mark;
    res_t tail;
    mark = pins_due.size();
    case (c.op)
      OP_RESET: begin
        tms_held = 1'b1;
        repeat (5) tick_pin(1'b1);
        belief = TAP_RESET;
      end
      OP_GO_IDLE: settle_idle();
      OP_LOAD_IR: shift_ir(c.instruction);
      OP_SHIFT_DR: begin
        enter_dr();
        // data bits keep the held TMS level unless exiting on the last one
        for (int i = 0; i < DATA_W; i++) begin
          tdi_held = c.data_word[i];
          if (i == DATA_W - 1 && c.exit_after) begin
            tms_held = 1'b1;
            tick_pin(1'b1);
            belief = TAP_DR_EXIT1;
            settle_idle();
          end else begin
            tick_pin(1'b1);
          end
        end
      end
      OP_LOAD_ADDR: begin
        shift_ir(c.instruction);
        enter_dr();
        belief = TAP_DR_SHIFT;
        for (int i = 0; i < ADDR_W; i++) begin
          tdi_held = c.address[i];
          if (i == ADDR_W - 1) begin
            tms_held = 1'b1;
            belief   = TAP_DR_EXIT1;
          end
          tick_pin(1'b1);
        end
        settle_idle();
      end
      default: ;
    endcase
    if (pins_due.size() == mark) tick_pin(1'b0);
    tail      = pins_due.pop_back();
    tail.last = 1'b1;
    if (c.op == OP_SHIFT_DR) tail.captured_word = c.tdo_levels;
    pins_due.push_back(tail);
  endtask

  task automatic check_pins(input res_t got);
    res_t want;
    seen++;
    if (pins_due.size() == 0) begin
      $error("result transfer with nothing pending");
      errors++;
    end else begin
      want = pins_due.pop_front();
      if (got.pulse !== want.pulse) begin
        $error("pulse: expected %0b, got %0b", want.pulse, got.pulse);
        errors++;
      end
      if (got.tms_level !== want.tms_level) begin
        $error("tms_level: expected %0b, got %0b", want.tms_level, got.tms_level);
        errors++;
      end
      if (got.tdi_level !== want.tdi_level) begin
        $error("tdi_level: expected %0b, got %0b", want.tdi_level, got.tdi_level);
        errors++;
      end
      if (got.captured_word !== want.captured_word) begin
        $error("captured_word: expected %h, got %h", want.captured_word,
               got.captured_word);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      belief   = TAP_RESET;
      tms_held = 1'b0;
      tdi_held = 1'b0;
      pins_due.delete();
    end else begin
      if (cmd_valid && cmd_ready) expand_cmd(cmd);
      if (res_valid && res_ready) check_pins(res);
    end
    fail_count   <= errors;
    pending      <= pins_due.size();
    results_seen <= seen;
  end

endmodule

@@ test/jtag_tap_master_shifter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtag_tap_master_shifter_test: testbench top for the JTAG TAP master
// Drives directed commands covering every op code and TAP belief corner,
// then random command sequences, with random gaps on both channels. The
// checker beside the block predicts every pulse; this top gives the verdict.
// ----------------------------------------------------------------------------
module jtag_tap_master_shifter_test;
  import jtm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_CMDS = 200;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd       = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  int fail_count;
  int pending;
  int results_seen;
  int cycle_count = 0;
  int sent        = 0;
  int directed    = 0;
  int rand_sent   = 0;
  bit gaps_on     = 1'b1;
  bit paused      = 1'b0;

  always #5 clk = ~clk;

  jtag_tap_master_shifter dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  jtag_tap_master_shifter_check chk (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always @(posedge clk) begin
    if (rst) res_ready <= 1'b0;
    else res_ready <= !gaps_on || ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("jtag_tap_master_shifter: mismatch");
      $finish;
    end
  end

  function automatic cmd_t mk_cmd(input logic [OP_W-1:0] op,
                                  input logic [INSTR_W-1:0] ir,
                                  input logic [DATA_W-1:0] dw,
                                  input logic [ADDR_W-1:0] ad,
                                  input logic ex,
                                  input logic [DATA_W-1:0] tdo);
    cmd_t c;
    c.op          = op;
    c.instruction = ir;
    c.data_word   = dw;
    c.address     = ad;
    c.exit_after  = ex;
    c.tdo_levels  = tdo;
    return c;
  endfunction

  function automatic cmd_t rand_cmd(input logic [OP_W-1:0] op, input logic ex);
    return mk_cmd(op, INSTR_W'($urandom), DATA_W'($urandom), ADDR_W'($urandom),
                  ex, DATA_W'($urandom));
  endfunction

  // Valid is only lowered for a gap or a drain, so back-to-back transfers keep it high.
  task automatic send_cmd(input cmd_t c);
    while (gaps_on && $urandom_range(99) < 18) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // belief starts in test logic reset with both pins low
    send_cmd(mk_cmd(OP_LOAD_IR, '1, '0, '0, 1'b0, '0));
    send_cmd(mk_cmd(OP_SHIFT_DR, '0, '1, '0, 1'b0, 16'hA5A5));
    send_cmd(mk_cmd(OP_RESET, '0, '0, '0, 1'b0, '0));
    // held TMS high outside idle, then exit on the last bit
    send_cmd(mk_cmd(OP_SHIFT_DR, '0, '0, '1, 1'b1, '1));
    send_cmd(mk_cmd(OP_GO_IDLE, '0, '0, '0, 1'b0, '0));
    send_cmd(mk_cmd(OP_LOAD_IR, '1, '0, '0, 1'b0, '0));
    send_cmd(mk_cmd(OP_LOAD_IR, '0, '1, '1, 1'b1, '1));
    send_cmd(mk_cmd(OP_SHIFT_DR, '0, '0, '0, 1'b0, '1));
    send_cmd(mk_cmd(OP_SHIFT_DR, '1, '1, '0, 1'b0, '0));
    send_cmd(mk_cmd(OP_GO_IDLE, '0, '0, '0, 1'b0, '0));
    send_cmd(mk_cmd(OP_LOAD_ADDR, 10'h155, '0, '1, 1'b0, '0));
    send_cmd(mk_cmd(OP_SHIFT_DR, '0, 16'h8001, '0, 1'b1, 16'h7FFE));
    send_cmd(mk_cmd(OP_LOAD_ADDR, 10'h2AA, '0, '0, 1'b0, '0));
    send_cmd(mk_cmd(OP_SHIFT_DR, '0, 16'h5A5A, '0, 1'b0, 16'hC3C3));
    // address load while already in DR shift skips the instruction
    send_cmd(mk_cmd(OP_LOAD_ADDR, '1, '0, 13'h0AAA, 1'b0, '0));
    send_cmd(mk_cmd(OP_RESET, '0, '0, '0, 1'b0, '0));
    send_cmd(mk_cmd(OP_LOAD_ADDR, '0, '0, 13'h1555, 1'b0, '0));
    send_cmd(mk_cmd(OP_RESET, '0, '0, '0, 1'b0, '0));
    send_cmd(mk_cmd(OP_GO_IDLE, '0, '0, '0, 1'b0, '0));
    send_cmd(mk_cmd(OP_SHIFT_DR, '0, 16'h1234, '0, 1'b1, 16'hFEDC));
    for (int u = OP_LOAD_ADDR + 1; u < 2 ** OP_W; u++)
      send_cmd(rand_cmd(OP_W'(u), 1'($urandom)));
    directed = sent;
    drain();

    while (rand_sent < RANDOM_CMDS) begin
      gaps_on = !(rand_sent >= 80 && rand_sent < 130);
      if (!paused && rand_sent >= 110) begin
        paused = 1'b1;
        drain();
      end
      if ($urandom_range(99) < 75) begin
        // well-formed: optional reset, select a register, shift words
        if ($urandom_range(3) == 0) begin
          send_cmd(rand_cmd(OP_RESET, 1'($urandom)));
          send_cmd(rand_cmd(OP_GO_IDLE, 1'($urandom)));
          rand_sent += 2;
        end
        if ($urandom_range(1) != 0) send_cmd(rand_cmd(OP_LOAD_ADDR, 1'($urandom)));
        else send_cmd(rand_cmd(OP_LOAD_IR, 1'($urandom)));
        rand_sent++;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          send_cmd(rand_cmd(OP_SHIFT_DR, k == n - 1 && $urandom_range(9) != 0));
          rand_sent++;
        end
      end else begin
        send_cmd(rand_cmd(OP_W'($urandom), 1'($urandom)));
        rand_sent++;
      end
    end

    gaps_on = 1'b1;
    drain();
    repeat (40) @(posedge clk);

    $display("ran %0d commands (%0d directed) over all op codes, checked %0d results",
             sent, directed, results_seen);
    $display("gaps on both channels, one gap-free stretch, drains mid-run and at end");
    if (fail_count == 0) begin
      $display("jtag_tap_master_shifter: match");
    end else begin
      $display("jtag_tap_master_shifter: mismatch");
    end
    $finish;
  end

endmodule
